// ----- hw/rtl/alp_pkg.sv -----
// shared types, codes and constants of the address lease pool
package alp_pkg;

    localparam int LEASE_DEPTH_DEF = 64;
    localparam int ADDR_W          = 32;
    localparam int CLIENT_W        = 32;
    localparam int LIMIT_W         = 7;
    localparam int STATUS_W        = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    // lease table entry: valid flag on top of the client identifier
    localparam int ENTRY_W         = CLIENT_W + 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_LIMIT   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_EXISTING  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

    // input command codes
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic                capture;
        logic                cnt_clear;
        logic                calc;
        logic                scan;
        logic                sweep;
        logic                slot_write;
        logic                res_load;
        logic [STATUS_W-1:0] res_code;
        logic                out_load;
    } alp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic outside;
        logic scan_done;
        logic sweep_done;
        logic hit;
        logic free;
    } alp_sts_t;

endpackage

// ----- hw/rtl/alp_if.sv -----
// request and response channel interfaces
interface alp_req_if;
    import alp_pkg::*;
    logic                valid;
    logic                ready;
    logic                command;
    logic [CLIENT_W-1:0] client_id;

    modport source (output valid, output command, output client_id, input ready);
    modport sink (input valid, input command, input client_id, output ready);
endinterface

interface alp_rsp_if;
    import alp_pkg::*;
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   assigned_address;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output assigned_address, output status, input ready);
    modport sink (input valid, input assigned_address, input status, output ready);
endinterface

// ----- hw/rtl/alp_ram.sv -----
// generic single write port, single read port ram with registered read
module alp_ram
    import alp_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = LEASE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/alp_datapath.sv -----
// lease pool datapath: config registers, lease table, scan and result registers
module alp_datapath
    import alp_pkg::*;
#(
    parameter int LEASE_DEPTH = LEASE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  alp_cmd_t              cmd,
    output alp_sts_t              sts,
    input  logic [CLIENT_W-1:0]   client_id,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [ADDR_W-1:0]     assigned_address,
    output logic [STATUS_W-1:0]   status
);

    localparam int AW = $clog2(LEASE_DEPTH);
    localparam int CW = $clog2(LEASE_DEPTH + 1);
    localparam logic [CW-1:0]     DEPTH_C  = CW'(LEASE_DEPTH);
    localparam logic [ADDR_W-1:0] DEPTH_32 = ADDR_W'(LEASE_DEPTH);

    logic [ADDR_W-1:0]   server_address_reg;
    logic [ADDR_W-1:0]   subnet_mask_reg;
    logic [LIMIT_W-1:0]  client_limit_reg;

    logic [CLIENT_W-1:0] cid_reg;
    logic [ADDR_W-1:0]   start_reg;
    logic [CW-1:0]       lim_reg;
    logic [CW-1:0]       cnt_reg;
    logic                pipe_vld_reg;
    logic [AW-1:0]       pipe_idx_reg;
    logic                hit_reg;
    logic [AW-1:0]       hit_idx_reg;
    logic                free_reg;
    logic [AW-1:0]       free_idx_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [ADDR_W-1:0]   host;
    logic [ADDR_W-1:0]   derived_lim;
    logic [ADDR_W-1:0]   raw_lim;
    logic [CW-1:0]       lim_next;
    logic [ADDR_W-1:0]   last_addr;
    logic                cnt_end;
    logic                issue;
    logic                sweep_we;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic                slot_valid;
    logic [CLIENT_W-1:0] slot_client;
    logic [ADDR_W-1:0]   res_addr_next;

    // effective client limit, saturated at the table depth
    always_comb
    begin
        host        = ~subnet_mask_reg;
        derived_lim = (host < 32'd2) ? '0 : host - 32'd2;
        raw_lim     = (client_limit_reg == '0) ? derived_lim
                                               : ADDR_W'(client_limit_reg);
        lim_next    = (raw_lim > DEPTH_32) ? DEPTH_C : raw_lim[CW-1:0];
    end

    assign last_addr = start_reg + ADDR_W'(lim_reg) - 32'd1;

    assign cnt_end   = (cnt_reg == DEPTH_C);
    assign issue     = cmd.scan && !cnt_end;
    assign sweep_we  = cmd.sweep && !cnt_end;
    assign ram_we    = sweep_we || cmd.slot_write;
    assign ram_waddr = cmd.slot_write ? free_idx_reg : cnt_reg[AW-1:0];
    assign ram_wdata = cmd.slot_write ? {1'b1, cid_reg} : '0;

    alp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LEASE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign slot_valid  = ram_rdata[ENTRY_W-1];
    assign slot_client = ram_rdata[CLIENT_W-1:0];

    always_comb
    begin
        case (cmd.res_code)
            ST_EXISTING: res_addr_next = start_reg + ADDR_W'(hit_idx_reg);
            ST_NEW:      res_addr_next = start_reg + ADDR_W'(free_idx_reg);
            default:     res_addr_next = '0;
        endcase
    end

    assign sts.outside    = ((server_address_reg ^ last_addr) & subnet_mask_reg) != '0;
    assign sts.scan_done  = cnt_end && !pipe_vld_reg;
    assign sts.sweep_done = cnt_end;
    assign sts.hit        = hit_reg;
    assign sts.free       = free_reg;

    assign assigned_address = out_addr_reg;
    assign status           = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_address_reg <= '0;
            subnet_mask_reg    <= 32'hFFFF_FF00;
            client_limit_reg   <= '0;
            cnt_reg            <= '0;
            pipe_vld_reg       <= 1'b0;
            hit_reg            <= 1'b0;
            free_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SERVER_ADDRESS: server_address_reg <= cfg_data;
                    CFG_SUBNET_MASK:    subnet_mask_reg    <= cfg_data;
                    CFG_CLIENT_LIMIT:   client_limit_reg   <= cfg_data[LIMIT_W-1:0];
                    default:            ;
                endcase
            end

            if (cmd.cnt_clear)
            begin
                cnt_reg      <= '0;
                pipe_vld_reg <= 1'b0;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
            end
            else
            begin
                pipe_vld_reg <= issue;
                if (issue || sweep_we)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                // compare the word read in the previous cycle
                if (pipe_vld_reg)
                begin
                    if (slot_valid && slot_client == cid_reg && !hit_reg)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (!slot_valid && CW'(pipe_idx_reg) < lim_reg && !free_reg)
                    begin
                        free_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= cnt_reg[AW-1:0];
        if (pipe_vld_reg && slot_valid && slot_client == cid_reg && !hit_reg)
        begin
            hit_idx_reg <= pipe_idx_reg;
        end
        if (pipe_vld_reg && !slot_valid && CW'(pipe_idx_reg) < lim_reg && !free_reg)
        begin
            free_idx_reg <= pipe_idx_reg;
        end
        if (cmd.capture)
        begin
            cid_reg <= client_id;
        end
        if (cmd.calc)
        begin
            start_reg <= (server_address_reg & subnet_mask_reg) + 32'd2;
            lim_reg   <= lim_next;
        end
        if (cmd.res_load)
        begin
            res_addr_reg   <= res_addr_next;
            res_status_reg <= cmd.res_code;
        end
        if (cmd.out_load)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
        end
    end

    a_free_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg |-> CW'(free_idx_reg) < lim_reg)
        else $error("free slot found at or above the client limit");

    a_write_only_new: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.slot_write |-> free_reg && !hit_reg && cmd.res_code == ST_NEW)
        else $error("table written without a new lease");

endmodule

// ----- hw/rtl/alp_ctrl.sv -----
// lease pool controller state machine
module alp_ctrl
    import alp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_command,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output alp_cmd_t cmd,
    input  alp_sts_t sts
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_CALC,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_code = ST_EXHAUSTED;
        case (state_reg)
            S_INIT:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture   = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    state_next    = (in_command == CMD_CLEAR) ? S_CLEAR : S_CALC;
                end
            end
            S_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_done)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_CLEARED;
                    state_next   = S_DONE;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.outside)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_OUTSIDE;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.res_load = 1'b1;
                if (sts.hit)
                begin
                    cmd.res_code = ST_EXISTING;
                end
                else if (sts.free)
                begin
                    cmd.res_code   = ST_NEW;
                    cmd.slot_write = 1'b1;
                end
                else
                begin
                    cmd.res_code = ST_EXHAUSTED;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_word_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response word raised outside the done state");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_CLEAR || state_reg == S_CALC)
        else $error("accepted word did not start work");

endmodule

// ----- hw/rtl/address_lease_pool.sv -----
// address lease pool top level: controller, datapath and channel hookup
// a request is accepted, its pool start and limit computed, the table scanned one entry a cycle
// with registered read, then decided and loaded to the output; outside subnet skips the scan,
// clear sweeps the table; one word in work at a time: the next word is accepted once the
// previous result loads into the output register; a response held by the sink stalls the input
// after reset a clearing pass empties the table before any accept
module address_lease_pool
    import alp_pkg::*;
#(
    parameter int LEASE_DEPTH = LEASE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    alp_req_if.sink               req,
    alp_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    alp_cmd_t cmd;
    alp_sts_t sts;

    alp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_command (req.command),
        .in_ready   (req.ready),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    alp_datapath #(
        .LEASE_DEPTH (LEASE_DEPTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .client_id        (req.client_id),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .assigned_address (rsp.assigned_address),
        .status           (rsp.status)
    );

endmodule

// ----- tb/tb_address_lease_pool.sv -----
// testbench for the address lease pool: directed and random lease traffic checked against a predictor
module tb_address_lease_pool;
    import alp_pkg::*;

    localparam int    DEPTH       = LEASE_DEPTH_DEF;
    localparam int    HOLD_CYCLES = 400;
    localparam int    TAIL_CYCLES = DEPTH + 10;
    localparam longint RUN_LIMIT  = 64'd30_000_000;

    typedef struct {
        logic [ADDR_W-1:0]   addr;
        logic [STATUS_W-1:0] status;
    } lease_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    alp_req_if req_ch ();
    alp_rsp_if rsp_ch ();

    address_lease_pool i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the registers and the lease table
    logic [ADDR_W-1:0]   srv_addr;
    logic [ADDR_W-1:0]   net_mask;
    logic [LIMIT_W-1:0]  max_clients;
    logic                lease_valid [DEPTH];
    logic [CLIENT_W-1:0] lease_client [DEPTH];

    lease_result_t pending_leases [$];
    int            error_count;
    int            hold_requests;
    bit            no_idle;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [ADDR_W-1:0] pool_limit();
        logic [ADDR_W-1:0] lim;
        logic [ADDR_W-1:0] host;
        lim = {{(ADDR_W-LIMIT_W){1'b0}}, max_clients};
        if (lim == 0)
        begin
            host = ~net_mask;
            lim = (host < 2) ? '0 : host - 2;
        end
        if (lim > DEPTH)
            lim = DEPTH;
        return lim;
    endfunction

    function automatic void predict_lease(input logic cmd, input logic [CLIENT_W-1:0] cid,
                                          output logic [ADDR_W-1:0] addr,
                                          output logic [STATUS_W-1:0] status);
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] lim;
        logic [ADDR_W-1:0] last;
        addr = '0;
        if (cmd == CMD_CLEAR)
        begin
            for (int i = 0; i < DEPTH; i++)
                lease_valid[i] = 1'b0;
            status = ST_CLEARED;
            return;
        end
        start = (srv_addr & net_mask) + 2;
        lim = pool_limit();
        last = start + lim - 1;
        if (((srv_addr ^ last) & net_mask) != 0)
        begin
            status = ST_OUTSIDE;
            return;
        end
        // existing leases are found in any slot, even above a lowered limit
        for (int i = 0; i < DEPTH; i++)
        begin
            if (lease_valid[i] && lease_client[i] == cid)
            begin
                addr = start + i;
                status = ST_EXISTING;
                return;
            end
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i < lim && !lease_valid[i])
            begin
                lease_valid[i] = 1'b1;
                lease_client[i] = cid;
                addr = start + i;
                status = ST_NEW;
                return;
            end
        end
        status = ST_EXHAUSTED;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(20, 150);
    endfunction

    // one word on the request channel; valid stays high until the caller drops it
    task automatic send_word(input logic cmd, input logic [CLIENT_W-1:0] cid);
        int            gap;
        lease_result_t res;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.command   <= cmd;
        req_ch.client_id <= cid;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_lease(cmd, cid, res.addr, res.status);
        pending_leases.push_back(res);
    endtask

    task automatic request(input logic [CLIENT_W-1:0] cid);
        send_word(CMD_REQUEST, cid);
    endtask

    task automatic clear_table();
        send_word(CMD_CLEAR, $urandom());
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_leases.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SERVER_ADDRESS: srv_addr = data;
            CFG_SUBNET_MASK:    net_mask = data;
            CFG_CLIENT_LIMIT:   max_clients = data[LIMIT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // registers only change once every response is back
    task automatic set_pool(input logic [ADDR_W-1:0] srv, input logic [ADDR_W-1:0] mask,
                            input logic [LIMIT_W-1:0] lim);
        drain();
        write_reg(CFG_SERVER_ADDRESS, srv);
        write_reg(CFG_SUBNET_MASK, mask);
        write_reg(CFG_CLIENT_LIMIT, {{(CFG_DATA_W-LIMIT_W){1'b0}}, lim});
    endtask

    task automatic test_reset_defaults();
        request(32'h0000_0000);
        request(32'hFFFF_FFFF);
        request(32'h0000_0000);
        clear_table();
        request(32'h0000_0000);
    endtask

    task automatic test_register_extremes();
        // all-ones mask leaves no host part, so the derived limit floors at zero
        set_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0);
        request(32'h0000_0000);
        set_pool(32'hFFFF_FFFF, 32'hFFFF_FFFE, 7'd0);
        request(32'h0000_0000);
        set_pool(32'hFFFF_FFFF, 32'h0000_0000, 7'd0);
        request(32'h0000_0000);
        set_pool(32'h0A00_000D, 32'hFFFF_FFFC, 7'd1);
        request(32'h0000_0000);
        request(32'h5A5A_5A5A);
        // explicit limit larger than a /30 runs past the subnet
        set_pool(32'h0A00_000D, 32'hFFFF_FFFC, 7'd64);
        request(32'h0000_0000);
        set_pool(32'h0A00_000D, 32'hFFFF_FFFC, 7'd0);
        request(32'h0000_0000);
    endtask

    task automatic test_lookup_after_limit_drop();
        logic [CLIENT_W-1:0] ids [9];
        for (int i = 0; i < 9; i++)
            ids[i] = $urandom();
        set_pool(32'hC0A8_0101, 32'hFFFF_FF00, 7'd8);
        clear_table();
        for (int i = 0; i < 9; i++)
            request(ids[i]);
        set_pool(32'hC0A8_0101, 32'hFFFF_FF00, 7'd2);
        request(ids[7]);
        request(~ids[8]);
        // address follows the current server setting
        set_pool(32'h0A00_0001, 32'hFFFF_FF00, 7'd2);
        request(ids[7]);
    endtask

    task automatic test_full_pipeline_stall();
        set_pool($urandom(), 32'hFFFF_FF00, 7'd0);
        clear_table();
        drain();
        no_idle = 1'b1;
        hold_requests++;
        for (int i = 0; i < 12; i++)
            request($urandom());
        drain();
        no_idle = 1'b0;
    endtask

    task automatic pick_random_pool();
        int                prefix;
        int                r;
        logic [ADDR_W-1:0] mask;
        logic [LIMIT_W-1:0] lim;
        r = $urandom_range(0, 99);
        if (r < 70)
            prefix = $urandom_range(23, 29);
        else if (r < 85)
            prefix = -1;
        else
        begin
            case ($urandom_range(0, 3))
                0: prefix = 0;
                1: prefix = 30;
                2: prefix = 31;
                default: prefix = 32;
            endcase
        end
        if (prefix < 0)
            mask = $urandom();
        else if (prefix == 0)
            mask = '0;
        else
            mask = 32'hFFFF_FFFF << (32 - prefix);
        r = $urandom_range(0, 99);
        if (r < 35)
            lim = 7'd0;
        else if (r < 55)
            lim = LIMIT_W'($urandom_range(1, 8));
        else if (r < 65)
            lim = 7'd64;
        else
            lim = LIMIT_W'($urandom_range(1, 64));
        set_pool($urandom(), mask, lim);
    endtask

    // phases of requests drawn from a small client set, so leases get reused and fill up
    task automatic test_random_traffic(input int n_items);
        logic [CLIENT_W-1:0] clients [$];
        int                  sent;
        int                  len;
        int                  r;
        sent = 0;
        while (sent < n_items)
        begin
            pick_random_pool();
            no_idle = ($urandom_range(0, 4) == 0);
            clients.delete();
            len = $urandom_range(4, 72);
            for (int i = 0; i < len; i++)
                clients.push_back($urandom());
            len = $urandom_range(30, 70);
            for (int k = 0; k < len; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    clear_table();
                else if (r < 8)
                    request($urandom());
                else if (r < 10)
                    request(($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF);
                else
                    request(clients[$urandom_range(0, clients.size() - 1)]);
            end
            sent += len;
        end
        no_idle = 1'b0;
    endtask

    // response side: random stalls, plus a long hold-off on request
    initial
    begin
        int stall_left;
        int hold_left;
        int hold_served;
        stall_left  = 0;
        hold_left   = 0;
        hold_served = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 99) < 15)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                                         : $urandom_range(0, 3);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        lease_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_leases.size() == 0)
            begin
                $error("unexpected word: assigned_address %h status %0d",
                       rsp_ch.assigned_address, rsp_ch.status);
                error_count++;
            end
            else
            begin
                want = pending_leases.pop_front();
                if (rsp_ch.assigned_address !== want.addr)
                begin
                    $error("assigned_address: expected %h, actual %h",
                           want.addr, rsp_ch.assigned_address);
                    error_count++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        error_count   = 0;
        hold_requests = 0;
        no_idle       = 1'b0;
        srv_addr      = '0;
        net_mask      = 32'hFFFF_FF00;
        max_clients   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            lease_valid[i]  = 1'b0;
            lease_client[i] = '0;
        end
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.command   <= CMD_REQUEST;
        req_ch.client_id <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_lookup_after_limit_drop();
        test_full_pipeline_stall();
        test_random_traffic(800);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
